[rtl/scpr_pkg.sv]
// ----------------------------------------------------------------------------
// scpr_pkg
// Shared types and constants for the second-chance page replacer.
// ----------------------------------------------------------------------------
package scpr_pkg;

  localparam int unsigned FRAMES_DEFAULT = 16;
  localparam int unsigned PAGE_BITS      = 16;
  localparam int unsigned FRAME_IDX_W    = 4;
  localparam int unsigned SLOT_W         = 5;

  localparam logic [SLOT_W-1:0] SLOTS_RESET = 5'd16;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page_number;
    logic                 is_write;
  } req_t;

  typedef struct packed {
    logic                   page_fault;
    logic                   used_free_slot;
    logic                   evicted;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic [PAGE_BITS-1:0]   victim_page;
    logic                   victim_dirty;
  } rsp_t;

endpackage

[rtl/scpr_frame_mem.sv]
// ----------------------------------------------------------------------------
// scpr_frame_mem
// Page-number store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module scpr_frame_mem #(
  parameter int unsigned FRAMES = scpr_pkg::FRAMES_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(FRAMES)-1:0]      waddr_i,
  input  logic [scpr_pkg::PAGE_BITS-1:0] wdata_i,
  input  logic [$clog2(FRAMES)-1:0]      raddr_i,
  output logic [scpr_pkg::PAGE_BITS-1:0] rdata_o
);
  import scpr_pkg::*;

  logic [PAGE_BITS-1:0] mem_q [FRAMES];
  logic [PAGE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/scpr_ctrl.sv]
// ----------------------------------------------------------------------------
// scpr_ctrl
// Sequencer: pipelined hit search through the frame store, free-frame fill,
// clock-hand sweep over the reference bits, victim readout and response.
// ----------------------------------------------------------------------------
module scpr_ctrl #(
  parameter int unsigned FRAMES = scpr_pkg::FRAMES_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  scpr_pkg::req_t                   req_i,
  output logic                             rsp_valid_o,
  input  logic                             rsp_ready_i,
  output scpr_pkg::rsp_t                   rsp_o,
  input  logic [$clog2(FRAMES+1)-1:0]      n_i,
  output logic                             mem_we_o,
  output logic [$clog2(FRAMES)-1:0]        mem_waddr_o,
  output logic [scpr_pkg::PAGE_BITS-1:0]   mem_wdata_o,
  output logic [$clog2(FRAMES)-1:0]        mem_raddr_o,
  input  logic [scpr_pkg::PAGE_BITS-1:0]   mem_rdata_i
);
  import scpr_pkg::*;

  localparam int unsigned IDX_W = $clog2(FRAMES);
  localparam int unsigned CNT_W = $clog2(FRAMES + 1);
  localparam int unsigned EW    = IDX_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SWEEP,
    S_VREAD
  } state_e;

  state_e               state_q;
  logic [PAGE_BITS-1:0] page_q;
  logic                 wr_q;
  logic [CNT_W-1:0]     resident_q;
  logic [CNT_W-1:0]     issue_q;
  logic                 cmp_valid_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic [IDX_W-1:0]     victim_q;
  logic [IDX_W-1:0]     hand_q;
  logic [CNT_W-1:0]     filled_q;
  logic [FRAMES-1:0]    ref_q;
  logic [FRAMES-1:0]    mod_q;
  logic                 rsp_valid_q;
  rsp_t                 rsp_q;

  logic             issue_more;
  logic             hit;
  logic             miss;
  logic             fill_ok;
  logic [EW-1:0]    at_inc;
  logic [IDX_W-1:0] hand_next;
  logic [IDX_W-1:0] hand_start;
  logic [IDX_W-1:0] fill_idx;

  always_comb begin
    issue_more = issue_q < resident_q;
    hit        = cmp_valid_q && (mem_rdata_i == page_q);
    miss       = (state_q == S_SEARCH) && !hit && !cmp_valid_q && !issue_more;
    fill_ok    = filled_q < n_i;
    fill_idx   = IDX_W'(filled_q);
    at_inc     = EW'(hand_q) + EW'(1);
    hand_next  = (at_inc >= EW'(n_i)) ? '0 : IDX_W'(at_inc);
    hand_start = (EW'(hand_q) >= EW'(n_i)) ? '0 : hand_q;

    mem_raddr_o = '0;
    case (state_q)
      S_SEARCH: mem_raddr_o = IDX_W'(issue_q);
      S_SWEEP:  mem_raddr_o = hand_q;
      default:  mem_raddr_o = '0;
    endcase

    mem_wdata_o = page_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = victim_q;
    if (miss && fill_ok) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = fill_idx;
    end else if (state_q == S_VREAD) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = victim_q;
    end
  end

  assign req_ready_o = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ref_q       <= '0;
      mod_q       <= '0;
      filled_q    <= '0;
      hand_q      <= '0;
      rsp_valid_q <= 1'b0;
      cmp_valid_q <= 1'b0;
      issue_q     <= '0;
    end else begin
      if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i && req_ready_o) begin
            page_q      <= req_i.page_number;
            wr_q        <= req_i.is_write;
            resident_q  <= (filled_q < n_i) ? filled_q : n_i;
            issue_q     <= '0;
            cmp_valid_q <= 1'b0;
            state_q     <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          // reads stream out one per cycle; compare trails on the registered read data
          cmp_valid_q <= issue_more;
          cmp_idx_q   <= IDX_W'(issue_q);
          if (issue_more) begin
            issue_q <= issue_q + CNT_W'(1);
          end
          if (hit) begin
            ref_q[cmp_idx_q]       <= 1'b1;
            mod_q[cmp_idx_q]       <= mod_q[cmp_idx_q] | wr_q;
            rsp_q.page_fault       <= 1'b0;
            rsp_q.used_free_slot   <= 1'b0;
            rsp_q.evicted          <= 1'b0;
            rsp_q.frame_index      <= FRAME_IDX_W'(cmp_idx_q);
            rsp_q.victim_page      <= '0;
            rsp_q.victim_dirty     <= 1'b0;
            rsp_valid_q            <= 1'b1;
            state_q                <= S_IDLE;
          end else if (miss) begin
            if (fill_ok) begin
              ref_q[fill_idx]      <= 1'b1;
              mod_q[fill_idx]      <= wr_q;
              filled_q             <= filled_q + CNT_W'(1);
              rsp_q.page_fault     <= 1'b1;
              rsp_q.used_free_slot <= 1'b1;
              rsp_q.evicted        <= 1'b0;
              rsp_q.frame_index    <= FRAME_IDX_W'(fill_idx);
              rsp_q.victim_page    <= '0;
              rsp_q.victim_dirty   <= 1'b0;
              rsp_valid_q          <= 1'b1;
              state_q              <= S_IDLE;
            end else begin
              hand_q  <= hand_start;
              state_q <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          hand_q <= hand_next;
          if (!ref_q[hand_q]) begin
            victim_q <= hand_q;
            state_q  <= S_VREAD;
          end else begin
            ref_q[hand_q] <= 1'b0;
          end
        end
        S_VREAD: begin
          ref_q[victim_q]      <= 1'b1;
          mod_q[victim_q]      <= wr_q;
          rsp_q.page_fault     <= 1'b1;
          rsp_q.used_free_slot <= 1'b0;
          rsp_q.evicted        <= 1'b1;
          rsp_q.frame_index    <= FRAME_IDX_W'(victim_q);
          rsp_q.victim_page    <= mem_rdata_i;
          rsp_q.victim_dirty   <= mod_q[victim_q];
          rsp_valid_q          <= 1'b1;
          state_q              <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CNT_W'(FRAMES))
    else $error("filled count above frame count");

  a_filled_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filled_q != $past(filled_q)) |-> (filled_q == $past(filled_q) + CNT_W'(1)))
    else $error("filled count moved by other than one");

  a_evict_is_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.evicted) |-> (rsp_o.page_fault && !rsp_o.used_free_slot))
    else $error("eviction response without a replacing fault");

  a_hand_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> (EW'(hand_q) < EW'(n_i)))
    else $error("clock hand outside managed frames");

  a_ready_no_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> !rsp_valid_o)
    else $error("ready while a response is pending");
`endif

endmodule

[rtl/second_chance_page_replacer.sv]
// ----------------------------------------------------------------------------
// second_chance_page_replacer
// Clock (second-chance) page replacement table with reference and dirty bits.
// ----------------------------------------------------------------------------
// One request is handled at a time; ready drops from acceptance until the
// response has been taken. The search reads the frame store one frame per
// cycle through its single read port and compares each frame in the cycle
// after its read, first match wins. A fault into a free frame runs the full
// search before it fills the frame. A fault on a full table adds the clock
// sweep, one frame per cycle, at most managed+1 frames, and then reads out
// the victim page. cfg_data_i sets the number of managed frames (0 acts as
// 1, values above FRAMES act as FRAMES) and is to be written only while no
// request is in flight.
module second_chance_page_replacer #(
  parameter int unsigned FRAMES = scpr_pkg::FRAMES_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [scpr_pkg::SLOT_W-1:0] cfg_data_i,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  scpr_pkg::req_t              req_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output scpr_pkg::rsp_t              rsp_o
);
  import scpr_pkg::*;

  localparam int unsigned IDX_W = $clog2(FRAMES);
  localparam int unsigned CNT_W = $clog2(FRAMES + 1);
  localparam int unsigned CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  logic [SLOT_W-1:0]    slots_q;
  logic [CMP_W-1:0]     slots_ext;
  logic [CNT_W-1:0]     n_frames;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [PAGE_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  logic [PAGE_BITS-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= SLOTS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      slots_q <= cfg_data_i;
    end
  end

  // clamp managed count into 1..FRAMES
  always_comb begin
    slots_ext = CMP_W'(slots_q);
    if (slots_ext == '0) begin
      n_frames = CNT_W'(1);
    end else if (slots_ext > CMP_W'(FRAMES)) begin
      n_frames = CNT_W'(FRAMES);
    end else begin
      n_frames = CNT_W'(slots_ext);
    end
  end

  scpr_ctrl #(
    .FRAMES(FRAMES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .n_i         (n_frames),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  scpr_frame_mem #(
    .FRAMES(FRAMES)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
